### rtl/hpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Types and constants of the homogeneous point transform unit.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int COEF_FRAC_BITS = 8;
    localparam int COORD_W        = 16;
    localparam int COEF_W         = 16;
    localparam int OUT_W          = 24;
    localparam int ROW_W          = 64;
    localparam int NUM_ROWS       = 4;
    localparam int NUM_COLS       = 4;
    localparam int NUM_AXES       = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int PROD_W         = COEF_W + COORD_W;
    localparam int BIAS_W         = COEF_W + 8;
    localparam int ACC_W          = PROD_W + 2;
    localparam int NUM_W          = ACC_W + 8;
    localparam int DEN_W          = ACC_W;
    localparam int WIDE_W         = DEN_W + OUT_W;
    localparam int NUM_PAD        = WIDE_W - NUM_W;
    localparam int DIV_STAGES     = OUT_W;

    // w of exactly zero is replaced by this value, 1.0 in accumulator scale
    localparam logic [ACC_W-1:0] W_ONE = ACC_W'(1) << (COEF_FRAC_BITS + 8);

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 4'd0,
        REG_ROW1 = 4'd1,
        REG_ROW2 = 4'd2,
        REG_ROW3 = 4'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
        logic                    w_was_zero;
        logic                    saturated;
    } result_t;

    // One divider stage: partial remainders and quotients of x, y, z
    typedef struct packed {
        logic [NUM_AXES-1:0][NUM_W-1:0] rem;
        logic [NUM_AXES-1:0][OUT_W-1:0] quo;
        logic [NUM_AXES-1:0]            neg;
        logic [NUM_AXES-1:0]            ovf;
        logic [DEN_W-1:0]               den;
        logic                           wz;
    } div_t;

endpackage

`default_nettype wire

### rtl/homogeneous_point_transform_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// 4x4 matrix transform of a Q8.8 point with perspective divide to Q16.8.
// ----------------------------------------------------------------------------
// One point is accepted and one result leaves per cycle while not stalled. In
// order: products, row sums, divider set-up, 24 restoring divider stages
// (one quotient bit each, for x, y and z side by side) and the output
// register. The whole pipeline advances together and holds while the output
// register is full and not taken. Matrix rows are written through the cfg
// channel, which is always ready; write them only while the pipeline is empty.
module homogeneous_point_transform_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire hpt_pkg::point_t              s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output hpt_pkg::result_t                  m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hpt_pkg::ROW_W-1:0]    cfg_data
);
    import hpt_pkg::*;

    logic [ROW_W-1:0] row_reg [NUM_ROWS];

    logic                     advance;
    logic                     va_reg, vb_reg;
    logic signed [PROD_W-1:0] prod_reg [NUM_ROWS][NUM_AXES];
    logic signed [BIAS_W-1:0] bias_reg [NUM_ROWS];
    logic signed [ACC_W-1:0]  acc_reg  [NUM_ROWS];
    logic [DIV_STAGES:0]      vd_reg;
    div_t                     div_reg  [DIV_STAGES+1];
    div_t                     div_init;
    div_t                     div_next [1:DIV_STAGES];
    result_t                  res_next;

    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
            row_reg[3] <= ROW3_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                default:  ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vd_reg  <= '0;
            m_valid <= 1'b0;
        end else if (advance) begin
            va_reg  <= s_valid;
            vb_reg  <= va_reg;
            vd_reg  <= {vd_reg[DIV_STAGES-1:0], vb_reg};
            m_valid <= vd_reg[DIV_STAGES];
        end
    end

    // ---------------- stage A: products ----------------
    logic signed [COORD_W-1:0] pt [NUM_AXES];
    assign pt[0] = s_data.point_x;
    assign pt[1] = s_data.point_y;
    assign pt[2] = s_data.point_z;

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_AXES; c++) begin
                    prod_reg[r][c] <= $signed(row_reg[r][COEF_W*c +: COEF_W]) * pt[c];
                end
                bias_reg[r] <= {$signed(row_reg[r][COEF_W*(NUM_COLS-1) +: COEF_W]), 8'b0};
            end
        end
    end

    // ---------------- stage B: row sums ----------------
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                acc_reg[r] <= ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                            + ACC_W'(prod_reg[r][2]) + ACC_W'(bias_reg[r]);
            end
        end
    end

    // ---------------- divider set-up and stages ----------------
    logic signed [ACC_W-1:0] den_s;
    logic                    den_neg;
    logic [DEN_W-1:0]        den_mag;
    logic signed [NUM_W-1:0] num_s [NUM_AXES];
    logic [NUM_W-1:0]        num_mag [NUM_AXES];

    always_comb begin
        den_s   = (acc_reg[NUM_ROWS-1] == '0) ? $signed(W_ONE) : acc_reg[NUM_ROWS-1];
        den_neg = den_s[ACC_W-1];
        den_mag = den_neg ? DEN_W'(-den_s) : DEN_W'(den_s);
        div_init.wz  = (acc_reg[NUM_ROWS-1] == '0);
        div_init.den = den_mag;
        for (int k = 0; k < NUM_AXES; k++) begin
            num_s[k]   = {acc_reg[k], 8'b0};
            num_mag[k] = num_s[k][NUM_W-1] ? NUM_W'(-num_s[k]) : NUM_W'(num_s[k]);
            div_init.rem[k] = num_mag[k];
            div_init.quo[k] = '0;
            div_init.neg[k] = num_s[k][NUM_W-1] ^ den_neg;
            div_init.ovf[k] = {{NUM_PAD{1'b0}}, num_mag[k]}
                            >= {den_mag, {OUT_W{1'b0}}};
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        logic [WIDE_W-1:0] shd;
        logic [WIDE_W-1:0] r58;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            div_next[s] = div_reg[s-1];
            shd = {{OUT_W{1'b0}}, div_reg[s-1].den} << (DIV_STAGES - s);
            for (int k = 0; k < NUM_AXES; k++) begin
                r58 = {{NUM_PAD{1'b0}}, div_reg[s-1].rem[k]};
                if (r58 >= shd) begin
                    div_next[s].rem[k] = NUM_W'(r58 - shd);
                    div_next[s].quo[k][DIV_STAGES - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            div_reg[0] <= div_init;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    // ---------------- sign, clamp, output register ----------------
    logic [OUT_W-1:0] coord [NUM_AXES];
    logic [NUM_AXES-1:0] clip;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (!div_reg[DIV_STAGES].neg[k]) begin
                clip[k]  = div_reg[DIV_STAGES].ovf[k] || div_reg[DIV_STAGES].quo[k][OUT_W-1];
                coord[k] = clip[k] ? OUT_MAX : div_reg[DIV_STAGES].quo[k];
            end else begin
                clip[k]  = div_reg[DIV_STAGES].ovf[k] || (div_reg[DIV_STAGES].quo[k] > OUT_MIN);
                coord[k] = clip[k] ? OUT_MIN : OUT_W'(-div_reg[DIV_STAGES].quo[k]);
            end
        end
        res_next.out_x      = $signed(coord[0]);
        res_next.out_y      = $signed(coord[1]);
        res_next.out_z      = $signed(coord[2]);
        res_next.w_was_zero = div_reg[DIV_STAGES].wz;
        res_next.saturated  = |clip;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data <= res_next;
        end
    end

    // ---------------- assertions ----------------
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid straight after reset");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(vd_reg) && $stable(va_reg) && $stable(vb_reg))
        else $error("pipeline moved while stalled");

    a_wzero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[0] && div_reg[0].wz |-> div_reg[0].den == DEN_W'(W_ONE))
        else $error("zero w not replaced by one");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            m_data.out_x == OUT_MAX || m_data.out_x == OUT_MIN ||
            m_data.out_y == OUT_MAX || m_data.out_y == OUT_MIN ||
            m_data.out_z == OUT_MAX || m_data.out_z == OUT_MIN)
        else $error("saturated flag without a clamped coordinate");

endmodule

`default_nettype wire
